// ===== design/iqerc_pkg.sv =====
// Package for the IQ envelope root compressor: shared constants.
// No dependencies.
`timescale 1ns / 1ps
package iqerc_pkg;
  localparam int unsigned LevelWidth = 20;
  localparam int unsigned ScaleWidth = 24;
  localparam int unsigned PixelWidth = 8;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned PowerWidth = 32;
  // Bit pairs resolved by one square-root pipeline stage.
  localparam int unsigned PairsPerStage = 4;
  localparam logic [1:0] RegMinLevel = 2'd0;
  localparam logic [1:0] RegMaxLevel = 2'd1;
  localparam logic [1:0] RegScale = 2'd2;
endpackage

// ===== design/iq_envelope_root_compress.sv =====
// Top level of the IQ envelope root compressor.
// Depends on iqerc_pkg, iqerc_sqrt_pipe and iqerc_map.
`timescale 1ns / 1ps
// Takes one IQ sample per transfer and returns one B-mode pixel per transfer at a
// sustained rate of one item per clock while the master side does not stall. Each item
// forms I*I+Q*Q, then passes three pipelined square-root units (four bit pairs per stage)
// and a clamp/scale stage. With the default parameters the path from a sample transfer
// to its pixel on the master side runs through the power register, which is loaded at
// the transfer edge, then 8, 6 and 5 root stages (set by the 32, 24 and 20 bit root
// widths), two clamp/scale stages and the output register.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall on the master side holds every stage and nothing is lost or repeated.
// The end-of-block flag rides along as tlast. Configuration writes are accepted at
// any time but must only be made while no item is in flight.
module iq_envelope_root_compress #(
  parameter int unsigned ROOT_FRAC_BITS = 16,
  parameter int unsigned SCALE_FRAC_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata, // i_sample [15:0], q_sample [31:16]
  input  logic s_axis_tlast,        // end_of_block
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata,  // pixel_level [7:0]
  output logic m_axis_tlast,        // end_of_block_out
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import iqerc_pkg::*;
  localparam int unsigned F = ROOT_FRAC_BITS;
  localparam int unsigned EW = (PowerWidth + 2 * F + 1) / 2;
  localparam int unsigned CW = (EW + F + 1) / 2;
  localparam int unsigned RW = (CW + F + 1) / 2;
  // Stages before the map block: one power stage plus each sqrt pipe.
  localparam int unsigned D1 = 1 + (EW + PairsPerStage - 1) / PairsPerStage
                                 + (CW + PairsPerStage - 1) / PairsPerStage
                                 + (RW + PairsPerStage - 1) / PairsPerStage;

  logic [LevelWidth-1:0] min_q, max_q;
  logic [ScaleWidth-1:0] scale_q;
  logic en;
  logic pw_vld_q;
  logic [PowerWidth-1:0] pw_q;
  logic signed [PowerWidth-1:0] i_ext, q_ext;
  logic [D1-1:0] eob_line_q;
  logic e_vld, c_vld, r_vld, map_vld, map_eob;
  logic [EW-1:0] e_root;
  logic [CW-1:0] c_root;
  logic [RW-1:0] r_root;
  logic [PixelWidth-1:0] pixel;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= LevelWidth'(65536);
      max_q <= LevelWidth'(368538);
      scale_q <= ScaleWidth'(225900);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMinLevel: min_q <= cfg_data_i[LevelWidth-1:0];
        RegMaxLevel: max_q <= cfg_data_i[LevelWidth-1:0];
        RegScale:    scale_q <= cfg_data_i[ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves when the output register is free or drains this cycle.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Power stage: the samples are sign-extended before squaring so that the full
  // square survives; the sum is at most 2^31 and fits 32 bits unsigned.
  assign i_ext = {{(PowerWidth-SampleWidth){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
  assign q_ext = {{(PowerWidth-SampleWidth){s_axis_tdata[31]}}, s_axis_tdata[31:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_vld_q <= 1'b0;
    end else if (en) begin
      pw_vld_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= PowerWidth'(i_ext * i_ext) + PowerWidth'(q_ext * q_ext);
      eob_line_q <= {eob_line_q[D1-2:0], s_axis_tlast};
    end
  end

  iqerc_sqrt_pipe #(.IN_W(PowerWidth), .SH(2 * F)) u_root_e (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pw_vld_q), .v_i(pw_q),
    .valid_o(e_vld), .root_o(e_root));
  iqerc_sqrt_pipe #(.IN_W(EW), .SH(F)) u_root_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_vld), .v_i(e_root),
    .valid_o(c_vld), .root_o(c_root));
  iqerc_sqrt_pipe #(.IN_W(CW), .SH(F)) u_root_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_vld), .v_i(c_root),
    .valid_o(r_vld), .root_o(r_root));

  iqerc_map #(.ROOT_W(RW), .SHIFT(F + SCALE_FRAC_BITS)) u_map (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r_vld), .eob_i(eob_line_q[D1-1]),
    .root_i(r_root), .min_i(min_q), .max_i(max_q), .scale_i(scale_q),
    .valid_o(map_vld), .eob_o(map_eob), .pixel_o(pixel));

  // Output register separates the pipeline from the master side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= map_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= pixel;
      m_axis_tlast <= map_eob;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline held");
  a_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(en) && $past(map_vld) && $past(min_q) > $past(max_q) |-> m_axis_tdata == '0)
    else $error("min above max must give zero");
`endif
endmodule

// ===== design/iqerc_sqrt_pipe.sv =====
// Pipelined restoring square root, floor(sqrt(v * 2^SH)), a few bit pairs per stage.
// Depends on iqerc_pkg for the number of bit pairs per stage.
`timescale 1ns / 1ps
module iqerc_sqrt_pipe #(
  parameter int unsigned IN_W = 32,
  parameter int unsigned SH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [IN_W-1:0] v_i,
  output logic valid_o,
  output logic [(IN_W+SH+1)/2-1:0] root_o
);
  import iqerc_pkg::*;
  localparam int unsigned NP = (IN_W + SH + 1) / 2;
  localparam int unsigned RW = 2 * NP;
  localparam int unsigned AW = NP + 2;
  localparam int unsigned NS = (NP + PairsPerStage - 1) / PairsPerStage;

  logic [RW-1:0] x_q [1:NS];
  logic [NP-1:0] root_q [1:NS];
  logic [AW-1:0] rem_q [1:NS];
  logic [NS:1] vld_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] x_in;
    logic [NP-1:0] root_in;
    logic [AW-1:0] rem_in;
    logic vld_in;
    logic [RW-1:0] x_d;
    logic [NP-1:0] root_d;
    logic [AW-1:0] rem_d;
    if (s == 0) begin : g_head
      assign x_in = RW'(v_i) << SH;
      assign root_in = '0;
      assign rem_in = '0;
      assign vld_in = valid_i;
    end else begin : g_body
      assign x_in = x_q[s];
      assign root_in = root_q[s];
      assign rem_in = rem_q[s];
      assign vld_in = vld_q[s];
    end
    always_comb begin
      logic [AW-1:0] trial;
      logic [AW-1:0] r;
      trial = '0;
      r = rem_in;
      x_d = x_in;
      root_d = root_in;
      for (int k = 0; k < PairsPerStage; k++) begin
        if (s * PairsPerStage + k < NP) begin
          r = {r[AW-3:0], x_d[RW-1 -: 2]};
          x_d = x_d << 2;
          trial = AW'({root_d, 2'b01});
          root_d = root_d << 1;
          if (r >= trial) begin
            r = r - trial;
            root_d[0] = 1'b1;
          end
        end
      end
      rem_d = r;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s+1] <= x_d;
        root_q[s+1] <= root_d;
        rem_q[s+1] <= rem_d;
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o = root_q[NS];
endmodule

// ===== design/iqerc_map.sv =====
// Clamp, offset and scale stage: maps the rooted envelope onto an 8-bit pixel.
// Depends on iqerc_pkg.
`timescale 1ns / 1ps
module iqerc_map #(
  parameter int unsigned ROOT_W = 24,
  parameter int unsigned SHIFT = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic eob_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [iqerc_pkg::LevelWidth-1:0] min_i,
  input  logic [iqerc_pkg::LevelWidth-1:0] max_i,
  input  logic [iqerc_pkg::ScaleWidth-1:0] scale_i,
  output logic valid_o,
  output logic eob_o,
  output logic [iqerc_pkg::PixelWidth-1:0] pixel_o
);
  import iqerc_pkg::*;
  localparam int unsigned PW = LevelWidth + ScaleWidth;

  logic [LevelWidth-1:0] diff_d, diff_q;
  logic [PW-1:0] prod_d, prod_q;
  logic [PW-1:0] lvl;
  logic [1:0] vld_q, eob_q;

  always_comb begin
    logic [ROOT_W+LevelWidth-1:0] r;
    r = (ROOT_W+LevelWidth)'(root_i);
    if (r > (ROOT_W+LevelWidth)'(max_i)) r = (ROOT_W+LevelWidth)'(max_i);
    if (r < (ROOT_W+LevelWidth)'(min_i)) r = (ROOT_W+LevelWidth)'(min_i);
    diff_d = LevelWidth'(r - (ROOT_W+LevelWidth)'(min_i));
  end

  assign prod_d = PW'(diff_q) * PW'(scale_i);
  assign lvl = prod_q >> SHIFT;
  assign pixel_o = (lvl > PW'(255)) ? 8'hFF : lvl[PixelWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eob_q <= {eob_q[0], eob_i};
      diff_q <= diff_d;
      prod_q <= prod_d;
    end
  end
  assign valid_o = vld_q[1];
  assign eob_o = eob_q[1];
endmodule

// ===== tb/iq_envelope_root_compress_tb.sv =====
// Testbench for the IQ envelope root compressor: stream stimulus with random idling,
// a bit-exact predictor of the pixel mapping and an in-order scoreboard.
// Depends on iqerc_pkg and iq_envelope_root_compress.
`timescale 1ns / 1ps
module iq_envelope_root_compress_tb;
  import iqerc_pkg::*;

  localparam int unsigned RootFrac  = 16;
  localparam int unsigned ScaleFrac = 12;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  // One expected pixel transfer.
  typedef struct packed {
    logic [PixelWidth-1:0] pixel;
    logic                  eob;
  } pixel_t;

  // One row of the directed table; check_pixel set means pixel_want is typed in.
  typedef struct {
    logic signed [SampleWidth-1:0] i_val;
    logic signed [SampleWidth-1:0] q_val;
    logic                          eob;
    logic                          check_pixel;
    logic [PixelWidth-1:0]         pixel_want;
  } iq_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // i_sample [15:0], q_sample [31:16]
  logic s_axis_tlast = 1'b0;        // end_of_block
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // pixel_level [7:0]
  logic m_axis_tlast;               // end_of_block_out
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Predictor's copy of the registers.
  logic [LevelWidth-1:0] min_level_q;
  logic [LevelWidth-1:0] max_level_q;
  logic [ScaleWidth-1:0] scale_q;

  pixel_t expected_pixels[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  iq_envelope_root_compress dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Truncating square root of v * 2^sh, one bit pair at a time.
  function automatic logic [63:0] shifted_sqrt(logic [63:0] v, int unsigned sh);
    logic [127:0] wide;
    logic [65:0] rem;
    logic [65:0] trial;
    logic [63:0] root;
    wide = {64'd0, v} << sh;
    rem = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | 66'(wide[2*k +: 2]);
      trial = {root, 2'b01};
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic logic [PixelWidth-1:0] predict_pixel(logic signed [15:0] i_val,
                                                          logic signed [15:0] q_val);
    logic [16:0] mag_i;
    logic [16:0] mag_q;
    logic [63:0] power;
    logic [63:0] level;
    logic [63:0] prod;
    mag_i = i_val[15] ? 17'(-{i_val[15], i_val}) : 17'(i_val);
    mag_q = q_val[15] ? 17'(-{q_val[15], q_val}) : 17'(q_val);
    power = 64'(mag_i) * mag_i + 64'(mag_q) * mag_q;
    level = shifted_sqrt(shifted_sqrt(shifted_sqrt(power, 2 * RootFrac), RootFrac),
                         RootFrac);
    if (level > max_level_q) level = 64'(max_level_q);
    if (level < min_level_q) level = 64'(min_level_q);
    prod = ((level - min_level_q) * scale_q) >> (RootFrac + ScaleFrac);
    return (prod > 255) ? 8'd255 : prod[7:0];
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Drives one register write and leaves valid high; the caller drops it.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMinLevel: min_level_q = value[LevelWidth-1:0];
      RegMaxLevel: max_level_q = value[LevelWidth-1:0];
      default:     scale_q = value[ScaleWidth-1:0];
    endcase
  endtask

  task automatic set_levels(logic [31:0] lo, logic [31:0] hi, logic [31:0] gain);
    wait (expected_pixels.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    write_register(RegMinLevel, lo);
    write_register(RegMaxLevel, hi);
    write_register(RegScale, gain);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one sample after a random gap; the expectation is queued at the transfer.
  task automatic send_sample(logic signed [15:0] i_val, logic signed [15:0] q_val,
                             logic eob);
    int unsigned gap;
    pixel_t item;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q_val, i_val};
    s_axis_tlast <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    item.pixel = predict_pixel(i_val, q_val);
    item.eob = eob;
    expected_pixels.push_back(item);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7)) - 16'sd4;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed table: zero input, extremes, both signs and the end-of-block mark.
  iq_row_t directed_rows[] = '{
    '{16'sh0000, 16'sh0000, 1'b0, 1'b1, 8'd0},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 8'd254},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b1, 8'd254},
    '{16'sh8000, 16'sh0000, 1'b1, 1'b0, 8'd0},
    '{16'sh0000, 16'sh7fff, 1'b0, 1'b0, 8'd0},
    '{16'sh0001, 16'sh0000, 1'b0, 1'b1, 8'd0},
    '{16'shffff, 16'shffff, 1'b1, 1'b0, 8'd0},
    '{16'sh0100, 16'shff00, 1'b0, 1'b0, 8'd0},
    '{16'sh1234, 16'shedcc, 1'b1, 1'b0, 8'd0},
    '{16'sh0010, 16'sh0003, 1'b0, 1'b0, 8'd0},
    '{16'sh5555, 16'shaaaa, 1'b0, 1'b0, 8'd0},
    '{16'sh00ff, 16'sh0000, 1'b1, 1'b0, 8'd0}
  };

  // Receiver: random stalls, with stretches of none.
  initial begin : receive_side
    int unsigned stall;
    pixel_t want;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", m_axis_tdata, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want.pixel) report_mismatch("pixel_level", m_axis_tdata,
                                                         want.pixel);
        if (m_axis_tlast !== want.eob) report_mismatch("end_of_block_out", m_axis_tlast,
                                                       want.eob);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_valid_i || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : send_side
    logic [PixelWidth-1:0] got_pixel;
    min_level_q = 20'd65536;
    max_level_q = 20'd368538;
    scale_q = 24'd225900;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run at the reset settings.
    foreach (directed_rows[n]) begin
      got_pixel = predict_pixel(directed_rows[n].i_val, directed_rows[n].q_val);
      if (directed_rows[n].check_pixel && got_pixel !== directed_rows[n].pixel_want)
        report_mismatch("typed-in pixel", got_pixel, directed_rows[n].pixel_want);
      send_sample(directed_rows[n].i_val, directed_rows[n].q_val, directed_rows[n].eob);
    end
    idle_sender();

    // Min above max forces every pixel to zero; full gain saturates everything else.
    set_levels(32'hfffff, 32'd0, 32'hffffff);
    repeat (6) send_sample(random_sample(), random_sample(), 1'($urandom));
    idle_sender();
    set_levels(32'd0, 32'hfffff, 32'hffffff);
    repeat (6) send_sample(random_sample(), random_sample(), 1'($urandom));
    idle_sender();
    set_levels(32'd0, 32'd0, 32'd0);
    repeat (4) send_sample(random_sample(), random_sample(), 1'($urandom));
    idle_sender();

    // Random phases with random register settings, the reset values among them.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) set_levels(32'd65536, 32'd368538, 32'd225900);
      else set_levels($urandom_range(0, 400000), $urandom_range(100000, 1048575),
                      $urandom_range(0, 16777215) >> $urandom_range(0, 10));
      repeat (100) send_sample(random_sample(), random_sample(), 1'($urandom));
      idle_sender();
    end

    wait (expected_pixels.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
